/* sv/sars_pkg.sv */
package sars_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 11;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

endpackage

/* sv/sorted_array_range_search.sv */
// sorted array range search
// s_ channel: one item per append, query or clear, picked by s_tuser. appends
// write the next free entry of the internal store (dropped when full), a clear
// empties the array, and neither gives a result
// m_ channel: one item per query with found in m_tuser and the first and last
// index of the target in m_tdata, both all ones when the target is absent
// an append or clear is done when taken and leaves s_tready high. a query runs a lower bound search, one
// read to check the hit, then an upper bound search, on a single comparator
// and the store's single read port; each search step is a read state and a
// compare state, and a query holds s_tready low until its result is in the
// output register
// one finished result waits in the output register; the block keeps taking
// appends and clears while it waits, and a further query stalls at its end
// until the output register is free
// reset (aresetn low, synchronous) empties the array and drops any pending
// result; the stored values are not cleared and need no clearing pass
module sorted_array_range_search
    import sars_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*DATA_W-1:0]    s_tdata,   // element_value, target_value
    input  logic [OP_W-1:0]        s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // first_index, last_index, zero pad
    output logic                   m_tuser    // found
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LB_ADDR  = 3'd1;
    localparam logic [2:0] ST_LB_CMP   = 3'd2;
    localparam logic [2:0] ST_CHK_ADDR = 3'd3;
    localparam logic [2:0] ST_CHK_CMP  = 3'd4;
    localparam logic [2:0] ST_UB_ADDR  = 3'd5;
    localparam logic [2:0] ST_UB_CMP   = 3'd6;
    localparam logic [2:0] ST_OUT      = 3'd7;

    logic signed [DATA_W-1:0] store_mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]            rd_addr;

    logic [2:0]               state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            lo_reg, lo_next;
    logic [CW-1:0]            hi_reg, hi_next;
    logic [CW-1:0]            mid_reg, mid_next;
    logic [CW-1:0]            first_reg, first_next;
    logic                     hit_reg, hit_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_found_reg, m_found_next;
    logic [IDX_W-1:0]         m_first_reg, m_first_next;
    logic [IDX_W-1:0]         m_last_reg, m_last_next;

    logic                     in_acc;
    logic                     wr_en;
    logic [CW-1:0]            mid;
    logic                     is_lt;
    logic                     is_eq;
    logic                     go_right;
    logic [CW-1:0]            last_idx;
    logic [XW-1:0]            first_ext;
    logic [XW-1:0]            last_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign wr_en    = in_acc && (s_tuser == OP_APPEND) && (count_reg < CW'(DEPTH));

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // the one comparator, shared by both searches and the hit check
    assign is_lt    = rd_data_reg < key_reg;
    assign is_eq    = rd_data_reg == key_reg;
    assign go_right = (state_reg == ST_UB_CMP) ? (is_lt || is_eq) : is_lt;

    assign last_idx  = (lo_reg > first_reg) ? (lo_reg - CW'(1)) : first_reg;
    assign first_ext = XW'(first_reg);
    assign last_ext  = XW'(last_idx);

    // read address: the probe point during a search, the lower bound for the hit check
    always_comb begin
        if (state_reg == ST_CHK_ADDR) begin
            rd_addr = lo_reg[AW-1:0];
        end else begin
            rd_addr = mid[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[count_reg[AW-1:0]] <= s_tdata[DATA_W-1:0];
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        first_next   = first_reg;
        hit_next     = hit_reg;
        key_next     = key_reg;
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_first_next = m_first_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (s_tuser)
                        OP_APPEND: begin
                            if (wr_en) begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_QUERY: begin
                            key_next   = s_tdata[2*DATA_W-1:DATA_W];
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = ST_LB_ADDR;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LB_ADDR, ST_UB_ADDR: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid;
                    state_next = (state_reg == ST_LB_ADDR) ? ST_LB_CMP : ST_UB_CMP;
                end else if (state_reg == ST_LB_ADDR) begin
                    state_next = ST_CHK_ADDR;
                end else begin
                    hit_next   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_LB_CMP, ST_UB_CMP: begin
                if (go_right) begin
                    lo_next = mid_reg + CW'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = (state_reg == ST_LB_CMP) ? ST_LB_ADDR : ST_UB_ADDR;
            end
            ST_CHK_ADDR: begin
                if (lo_reg < count_reg) begin
                    state_next = ST_CHK_CMP;
                end else begin
                    hit_next   = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_CHK_CMP: begin
                if (is_eq) begin
                    first_next = lo_reg;
                    hi_next    = count_reg;
                    state_next = ST_UB_ADDR;
                end else begin
                    hit_next   = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // upper bound sits in lo_reg when the search ends
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = hit_reg;
                    m_first_next = hit_reg ? first_ext[IDX_W-1:0] : '1;
                    m_last_next  = hit_reg ? last_ext[IDX_W-1:0] : '1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        first_reg   <= first_next;
        hit_reg     <= hit_next;
        key_reg     <= key_next;
        m_found_reg <= m_found_next;
        m_first_reg <= m_first_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {2'b00, m_last_reg, m_first_reg};

endmodule

/* test/sorted_array_range_search_tb.sv */
module sorted_array_range_search_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sars_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int IDLE_PCT       = 17;
    localparam int RANDOM_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam logic [OP_W-1:0] ALL_OPS [4] = '{OP_APPEND, OP_QUERY, OP_CLEAR, OP_IGNORED};

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                    found;
        logic signed [IDX_W-1:0] first_idx;
        logic signed [IDX_W-1:0] last_idx;
    } span_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*DATA_W-1:0]   s_tdata  = '0;
    logic [OP_W-1:0]       s_tuser  = OP_APPEND;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tuser;

    // shadow copy of the block's array
    logic signed [DATA_W-1:0] shadow_elems [DEPTH];
    int                       shadow_count = 0;

    span_t pending_spans [$];
    span_t want_span;
    int    err_cnt      = 0;
    int    items_sent   = 0;
    bit    no_gaps      = 1'b0;
    int    quiet_cycles = 0;

    sorted_array_range_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5ns aclk = ~aclk;

    // lower bound, then upper bound from there, same as the hardware walks them
    function automatic span_t predict_span(logic signed [DATA_W-1:0] key);
        int    lo;
        int    hi;
        int    mid;
        int    up;
        int    last_pos;
        span_t r;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (shadow_elems[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        if (lo < shadow_count && shadow_elems[lo] == key) begin
            up = lo;
            hi = shadow_count;
            while (up < hi) begin
                mid = up + ((hi - up) >> 1);
                if (shadow_elems[mid] <= key) up = mid + 1;
                else hi = mid;
            end
            last_pos    = (up > lo) ? up - 1 : lo;
            r.found     = 1'b1;
            r.first_idx = lo[IDX_W-1:0];
            r.last_idx  = last_pos[IDX_W-1:0];
        end else begin
            r.found     = 1'b0;
            r.first_idx = '1;
            r.last_idx  = '1;
        end
        return r;
    endfunction

    function automatic void apply_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] elem,
                                       logic signed [DATA_W-1:0] tgt);
        case (op)
            OP_APPEND: begin
                if (shadow_count < DEPTH) begin
                    shadow_elems[shadow_count] = elem;
                    shadow_count++;
                end
            end
            OP_CLEAR: shadow_count = 0;
            OP_QUERY: pending_spans.push_back(predict_span(tgt));
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] elem,
                             input logic signed [DATA_W-1:0] tgt);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tgt, elem};
        do @(posedge aclk); while (!s_tready);
        apply_item(op, elem, tgt);
        if (op != OP_IGNORED) items_sent++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_spans.size() != 0) @(posedge aclk);
    endtask

    // non-decreasing run, mostly small steps so duplicates are common
    task automatic load_sorted(input int n);
        longint v;
        v = longint'($signed($urandom));
        if ($urandom_range(3) == 0) v = longint'(VAL_MIN) + $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            send_item(OP_APPEND, v[DATA_W-1:0], $urandom);
            if ($urandom_range(3) == 0) v += $urandom_range(1000000);
            else v += $urandom_range(2);
            if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
        end
    endtask

    task automatic random_query();
        logic signed [DATA_W-1:0] tgt;
        int                       pick;
        pick = $urandom_range(9);
        if (shadow_count == 0 || pick >= 8) begin
            if (pick == 9) tgt = $urandom_range(1) ? VAL_MAX : VAL_MIN;
            else tgt = $urandom;
        end else begin
            tgt = shadow_elems[$urandom_range(shadow_count - 1)];
            // just beside a stored value, usually absent
            if (pick >= 6) tgt = tgt + ((pick == 6) ? 1 : -1);
        end
        send_item(OP_QUERY, $urandom, tgt);
    endtask

    task automatic test_empty_array();
        send_item(OP_QUERY, $urandom, 0);
        send_item(OP_QUERY, $urandom, VAL_MIN);
    endtask

    task automatic test_extremes();
        send_item(OP_APPEND, VAL_MIN, $urandom);
        send_item(OP_APPEND, VAL_MIN, $urandom);
        send_item(OP_APPEND, -1, $urandom);
        send_item(OP_APPEND, 0, $urandom);
        send_item(OP_APPEND, 0, $urandom);
        send_item(OP_APPEND, 7, $urandom);
        send_item(OP_APPEND, VAL_MAX, $urandom);
        send_item(OP_APPEND, VAL_MAX, $urandom);
        send_item(OP_QUERY, $urandom, VAL_MIN);
        send_item(OP_QUERY, $urandom, VAL_MAX);
        send_item(OP_QUERY, $urandom, 0);
        send_item(OP_QUERY, $urandom, 7);
        send_item(OP_QUERY, $urandom, 1);
    endtask

    task automatic test_ignored_and_clear();
        send_item(OP_IGNORED, $urandom, $urandom);
        send_item(OP_QUERY, $urandom, 0);
        send_item(OP_CLEAR, $urandom, $urandom);
        send_item(OP_QUERY, $urandom, 0);
    endtask

    task automatic test_unsorted();
        send_item(OP_APPEND, 9, $urandom);
        send_item(OP_APPEND, 3, $urandom);
        send_item(OP_APPEND, 7, $urandom);
        send_item(OP_APPEND, 3, $urandom);
        send_item(OP_QUERY, $urandom, 3);
        send_item(OP_QUERY, $urandom, 9);
        send_item(OP_QUERY, $urandom, 7);
    endtask

    task automatic test_fill_to_capacity();
        hold_until_drained();
        send_item(OP_CLEAR, $urandom, $urandom);
        // the last two appends find the array full and are dropped
        load_sorted(DEPTH + 2);
        send_item(OP_QUERY, $urandom, shadow_elems[DEPTH-1]);
        send_item(OP_QUERY, $urandom, shadow_elems[0]);
        send_item(OP_QUERY, $urandom, VAL_MAX);
        repeat (4) random_query();
    endtask

    task automatic test_random_rounds();
        int goal;
        int round;
        goal  = items_sent + RANDOM_ITEMS;
        round = 0;
        while (items_sent < goal) begin
            round++;
            no_gaps = (round >= 12 && round < 20);
            if ($urandom_range(99) < 85) begin
                send_item(OP_CLEAR, $urandom, $urandom);
                if ($urandom_range(19) == 0) load_sorted($urandom_range(100, 300));
                else load_sorted($urandom_range(24));
                repeat ($urandom_range(1, 8)) random_query();
            end else begin
                // noise: any code, random values, leaves the array unsorted
                repeat ($urandom_range(1, 10))
                    send_item(ALL_OPS[$urandom_range(3)], $urandom, $urandom);
            end
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_spans.size() == 0) begin
                $error("result item with no query pending");
                err_cnt++;
            end else begin
                want_span = pending_spans.pop_front();
                if (m_tuser !== want_span.found) begin
                    $error("found: expected %0d, actual %0d", want_span.found, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[IDX_W-1:0] !== want_span.first_idx) begin
                    $error("first_index: expected %0d, actual %0d", want_span.first_idx,
                           $signed(m_tdata[IDX_W-1:0]));
                    err_cnt++;
                end
                if (m_tdata[2*IDX_W-1:IDX_W] !== want_span.last_idx) begin
                    $error("last_index: expected %0d, actual %0d", want_span.last_idx,
                           $signed(m_tdata[2*IDX_W-1:IDX_W]));
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_array();
        test_extremes();
        test_ignored_and_clear();
        test_unsorted();
        test_fill_to_capacity();
        test_random_rounds();
        s_tvalid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
